/* src/sird_pkg.sv */
package sird_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int BASE_W     = 5;
  localparam int STEPS_PER_CYCLE = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_SIZE_RST  = 5'd10;
  localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST = 64'd5063528411713059128;
  localparam logic [7:0]            MINUS_CHAR     = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
    logic out_load;
    logic out_sign;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic mag_zero;
    logic negative;
    logic last_digit;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [CFG_DATA_W-1:0] lo,
                                            input logic [CFG_DATA_W-1:0] hi,
                                            input logic [3:0] idx);
    logic [2*CFG_DATA_W-1:0] tbl;
    tbl = {hi, lo};
    return tbl[{idx, 3'b000} +: 8];
  endfunction

endpackage

/* src/sird_ctrl.sv */
module sird_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sird_pkg::status_t status,
  output sird_pkg::cmd_t    cmd
);

  sird_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != sird_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sird_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sird_pkg::ST_DIV;
      end
      sird_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = sird_pkg::ST_CHECK;
      end
      sird_pkg::ST_CHECK: begin
        if (!status.mag_zero) state_nxt = sird_pkg::ST_DIV;
        else if (status.negative) state_nxt = sird_pkg::ST_SIGN;
        else state_nxt = sird_pkg::ST_EMIT;
      end
      sird_pkg::ST_SIGN: begin
        if (out_free) state_nxt = sird_pkg::ST_EMIT;
      end
      sird_pkg::ST_EMIT: begin
        if (out_free && status.last_digit) state_nxt = sird_pkg::ST_IDLE;
      end
      default: state_nxt = sird_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      sird_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      sird_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      sird_pkg::ST_SIGN: begin
        cmd.out_load = out_free;
        cmd.out_sign = 1'b1;
      end
      sird_pkg::ST_EMIT: begin
        cmd.out_load = out_free;
        cmd.pop      = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sird_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/sird_dp.sv */
module sird_dp #(
  parameter int MAX_BASE    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  input  sird_pkg::cmd_t                      cmd,
  output sird_pkg::status_t                   status,
  output logic [7:0]                          out_char_out,
  output logic                                out_is_last
);

  localparam int DW        = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
  localparam int RW        = DW + 1;
  localparam int SPC       = sird_pkg::STEPS_PER_CYCLE;
  localparam int DIV_ITERS = (VALUE_WIDTH + SPC - 1) / SPC;
  localparam int PAD_W     = DIV_ITERS * SPC;
  localparam int IW        = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
  localparam int CW        = $clog2(VALUE_WIDTH + 1);
  localparam int STK_W     = VALUE_WIDTH * DW;
  localparam int BW        = sird_pkg::BASE_W;

  logic [BW-1:0]                   base_size_r, base_size_nxt;
  logic [sird_pkg::CFG_DATA_W-1:0] chars_lo_r, chars_lo_nxt;
  logic [sird_pkg::CFG_DATA_W-1:0] chars_hi_r, chars_hi_nxt;

  logic             neg_r, neg_nxt;
  logic [PAD_W-1:0] work_r, work_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [IW-1:0]    iter_r, iter_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [STK_W-1:0] stk_r, stk_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;

  logic [BW-1:0]          radix_full;
  logic [RW-1:0]          radix;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic [RW-1:0]          step_rem;
  logic [PAD_W-1:0]       step_work;
  logic                   iter_last;
  logic [DW-1:0]          top_digit;
  logic [3:0]             tbl_idx;

  always_comb begin
    if (base_size_r < BW'(2)) radix_full = BW'(2);
    else if (base_size_r > BW'(MAX_BASE)) radix_full = BW'(MAX_BASE);
    else radix_full = base_size_r;
  end
  assign radix = radix_full[RW-1:0];

  assign raw = in_value;
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    logic [RW-1:0]    r;
    logic [PAD_W-1:0] w;
    r = rem_r;
    w = work_r;
    for (int i = 0; i < SPC; i++) begin
      r = {r[RW-2:0], w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (r >= radix) begin
        r    = r - radix;
        w[0] = 1'b1;
      end
    end
    step_rem  = r;
    step_work = w;
  end

  assign iter_last = (iter_r == IW'(DIV_ITERS - 1));
  assign top_digit = stk_r[DW-1:0];
  assign tbl_idx   = 4'(top_digit);

  always_comb begin
    base_size_nxt = base_size_r;
    chars_lo_nxt  = chars_lo_r;
    chars_hi_nxt  = chars_hi_r;
    if (cfg_we) begin
      case (cfg_index)
        sird_pkg::REG_BASE_SIZE:  base_size_nxt = cfg_wdata[BW-1:0];
        sird_pkg::REG_CHARS_LOW:  chars_lo_nxt  = cfg_wdata;
        sird_pkg::REG_CHARS_HIGH: chars_hi_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    neg_nxt  = neg_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    cnt_nxt  = cnt_r;
    stk_nxt  = stk_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.load) begin
      neg_nxt  = raw[VALUE_WIDTH-1];
      work_nxt = PAD_W'(mag);
      rem_nxt  = '0;
      iter_nxt = '0;
      cnt_nxt  = '0;
    end else if (cmd.div_step) begin
      work_nxt = step_work;
      if (iter_last) begin
        iter_nxt = '0;
        rem_nxt  = '0;
        cnt_nxt  = cnt_r + 1'b1;
        if (STK_W > DW) stk_nxt = STK_W'({stk_r, step_rem[DW-1:0]});
        else stk_nxt = STK_W'(step_rem[DW-1:0]);
      end else begin
        iter_nxt = iter_r + 1'b1;
        rem_nxt  = step_rem;
      end
    end
    if (cmd.out_load) begin
      if (cmd.out_sign) begin
        char_nxt = sird_pkg::MINUS_CHAR;
        last_nxt = 1'b0;
      end else begin
        char_nxt = sird_pkg::digit_char(chars_lo_r, chars_hi_r, tbl_idx);
        last_nxt = (cnt_r == CW'(1));
      end
    end
    if (cmd.pop) begin
      stk_nxt = stk_r >> DW;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r <= sird_pkg::BASE_SIZE_RST;
      chars_lo_r  <= sird_pkg::CHARS_LOW_RST;
      chars_hi_r  <= sird_pkg::CHARS_HIGH_RST;
      iter_r      <= '0;
      cnt_r       <= '0;
    end else begin
      base_size_r <= base_size_nxt;
      chars_lo_r  <= chars_lo_nxt;
      chars_hi_r  <= chars_hi_nxt;
      iter_r      <= iter_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    stk_r  <= stk_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign status.div_last   = iter_last;
  assign status.mag_zero   = (work_r == '0);
  assign status.negative   = neg_r;
  assign status.last_digit = (cnt_r == CW'(1));

  assign out_char_out = char_r;
  assign out_is_last  = last_r;

endmodule

/* src/signed_int_to_radix_digits.sv */
// Each value is loaded, then divided by the radix once per digit in the shared
// 8-bit-per-cycle divider, then its characters leave the output register one per cycle
// while out_stall is low. A new value is accepted only after the last character of the
// previous value has been loaded into the output register.
// Reset (rst_n, synchronous, active low): idle, no result pending, base 10,
// digit symbols "0123456789ABCDEF".
module signed_int_to_radix_digits #(
  parameter int MAX_BASE    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sird_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_WIDTH-1:0]   in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_char_out,
  output logic                            out_is_last
);

  sird_pkg::cmd_t    cmd;
  sird_pkg::status_t status;

  sird_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sird_dp #(
    .MAX_BASE    (MAX_BASE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_value     (in_value),
    .cmd          (cmd),
    .status       (status),
    .out_char_out (out_char_out),
    .out_is_last  (out_is_last)
  );

endmodule

/* src/sird_chk.sv */
module sird_chk #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [VALUE_WIDTH-1:0] in_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    out_char_out,
  input logic                          out_is_last
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_value))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out) && $stable(out_is_last))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item still in work");

  a_ready_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid || out_is_last)
    else $error("ready while characters of a value are still pending");

  a_no_midvalue_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !(out_valid && !out_is_last))
    else $error("non-final character pending right after accept");

endmodule

bind signed_int_to_radix_digits sird_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_sird_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_value     (in_value),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_char_out (out_char_out),
  .out_is_last  (out_is_last)
);

/* test/tb_signed_int_to_radix_digits.sv */
`timescale 1ns / 100ps

module tb_signed_int_to_radix_digits;

  localparam int VW = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [sird_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  class radix_text_board;
    logic [sird_pkg::BASE_W-1:0]     base_size;
    logic [sird_pkg::CFG_DATA_W-1:0] chars_lo;
    logic [sird_pkg::CFG_DATA_W-1:0] chars_hi;
    text_char_t                      pending_chars[$];
    int                              errors;
    int                              values_seen;
    int                              chars_checked;

    function new();
      base_size = sird_pkg::BASE_SIZE_RST;
      chars_lo  = sird_pkg::CHARS_LOW_RST;
      chars_hi  = sird_pkg::CHARS_HIGH_RST;
      errors = 0;
      values_seen = 0;
      chars_checked = 0;
    endfunction

    function void set_reg(logic [sird_pkg::CFG_IDX_W-1:0] idx,
                          logic [sird_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sird_pkg::REG_BASE_SIZE:  base_size = data[sird_pkg::BASE_W-1:0];
        sird_pkg::REG_CHARS_LOW:  chars_lo = data;
        sird_pkg::REG_CHARS_HIGH: chars_hi = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] symbol(logic [3:0] d);
      if (d < 4'd8) return chars_lo[{d[2:0], 3'b000} +: 8];
      return chars_hi[{d[2:0], 3'b000} +: 8];
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    // text of one accepted value, sign first, most significant digit next
    function void add_value_chars(logic [VW-1:0] v);
      logic [VW-1:0] mag;
      logic [4:0]    radix;
      logic [3:0]    digs[$];
      text_char_t    c;
      values_seen++;
      radix = base_size;
      if (radix < 5'd2) radix = 5'd2;
      if (radix > 5'd16) radix = 5'd16;
      mag = v;
      if (v[VW-1]) mag = ~v + 1'b1;
      do begin
        digs.push_back(4'(mag % radix));
        mag = mag / radix;
      end while (mag != 0);
      if (v[VW-1]) begin
        c.ch = sird_pkg::MINUS_CHAR;
        c.is_last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int k = digs.size() - 1; k >= 0; k--) begin
        c.ch = symbol(digs[k]);
        c.is_last = (k == 0);
        pending_chars.push_back(c);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_char(logic [7:0] ch, logic is_last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char %h last %b with nothing pending", ch, is_last));
        return;
      end
      want = pending_chars.pop_front();
      chars_checked++;
      if (ch !== want.ch)
        report_mismatch($sformatf("char %h, want %h", ch, want.ch));
      if (is_last !== want.is_last)
        report_mismatch($sformatf("is_last %b, want %b (char %h)", is_last, want.is_last,
                                  want.ch));
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sird_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid;
  logic                            in_stall;
  logic signed [VW-1:0]            in_value;
  logic                            out_valid;
  logic                            out_stall;
  logic [7:0]                      out_char_out;
  logic                            out_is_last;

  radix_text_board sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  int cfg_writes = 0;

  signed_int_to_radix_digits #(
    .MAX_BASE    (16),
    .VALUE_WIDTH (VW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_out (out_char_out),
    .out_is_last  (out_is_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    if (rst_n && in_valid && !in_stall) sb.add_value_chars(in_value);
    if (rst_n && out_valid && !out_stall) sb.check_char(out_char_out, out_is_last);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_value(logic [VW-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [sird_pkg::CFG_IDX_W-1:0] idx,
                           logic [sird_pkg::CFG_DATA_W-1:0] data);
    pause_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  initial begin
    logic [sird_pkg::CFG_DATA_W-1:0] wdata;
    logic [VW-1:0]                   v;
    int                              base;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_value  = '0;
    send_idle_pct = 17;
    recv_idle_pct = 64;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: decimal, default symbols
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd10);
    send_value(-32'sd10);

    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd2);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'hffff_ffff);
    send_value(32'd0);

    cfg_write(sird_pkg::REG_BASE_SIZE, {{59{1'b1}}, 5'd16});
    cfg_write(sird_pkg::REG_CHARS_LOW, 64'h6867_6665_6463_6261);
    cfg_write(sird_pkg::REG_CHARS_HIGH, 64'h706f_6e6d_6c6b_6a69);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'h0123_abcd);

    // radix clamped below two and above the table
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd0);
    send_value(32'd5);
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd1);
    send_value(-32'sd6);
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd17);
    send_value(32'h8000_0000);
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd31);
    send_value(32'd255);

    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd16);
    cfg_write(sird_pkg::REG_CHARS_LOW, 64'd0);
    cfg_write(sird_pkg::REG_CHARS_HIGH, 64'd0);
    send_value(32'h1234_5678);
    cfg_write(sird_pkg::REG_CHARS_LOW, '1);
    cfg_write(sird_pkg::REG_CHARS_HIGH, '1);
    send_value(32'h89ab_cdef);

    // write to an unused index must change nothing
    cfg_write(sird_pkg::REG_CHARS_LOW, sird_pkg::CHARS_LOW_RST);
    cfg_write(sird_pkg::REG_CHARS_HIGH, sird_pkg::CHARS_HIGH_RST);
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd10);
    cfg_write(REG_UNUSED, {$urandom, $urandom});
    send_value(32'd12345);
    cfg_write(sird_pkg::REG_BASE_SIZE, 64'd3);
    send_value(-32'sd7);

    for (int ph = 0; ph < 3; ph++) begin
      pause_for_results();
      case (ph)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        if ($urandom_range(3) == 0) base = $urandom_range(31);
        else base = $urandom_range(2, 16);
        wdata = {$urandom, $urandom};
        wdata[sird_pkg::BASE_W-1:0] = base[sird_pkg::BASE_W-1:0];
        cfg_write(sird_pkg::REG_BASE_SIZE, wdata);
        if ($urandom_range(1)) cfg_write(sird_pkg::REG_CHARS_LOW, {$urandom, $urandom});
        if ($urandom_range(1)) cfg_write(sird_pkg::REG_CHARS_HIGH, {$urandom, $urandom});
        if ($urandom_range(5) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
        for (int i = 0; i < 21; i++) begin
          case ($urandom_range(4))
            0, 1: v = $urandom;
            2: begin
              v = $urandom >> $urandom_range(31);
              if ($urandom_range(1)) v = ~v + 1'b1;
            end
            3: v = VW'(-$signed($urandom_range(300)));
            default: begin
              case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'd0;
                default: v = 32'hffff_ffff;
              endcase
            end
          endcase
          send_value(v);
        end
      end
    end

    pause_for_results();
    repeat (200) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d chars never arrived", sb.pending()));
    $display("run: %0d values, %0d chars checked, %0d register writes", sb.values_seen,
             sb.chars_checked, cfg_writes);
    $display("radix 0..31 incl. clamped values, extreme integers, three stall mixes");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* signed_int_to_radix_digits.f */
src/sird_pkg.sv
src/sird_ctrl.sv
src/sird_dp.sv
src/signed_int_to_radix_digits.sv
src/sird_chk.sv
test/tb_signed_int_to_radix_digits.sv
